// ===== sv/fcth_pkg.sv =====
// ----------------------------------------------------------------------------
// fcth_pkg
// Shared types, constants and the built-in curve for the fan curve core.
// ----------------------------------------------------------------------------
package fcth_pkg;

  localparam int MaxAnchors  = 9;
  localparam int AnchorSlots = 9;
  localparam int AnchorLimit = (MaxAnchors < AnchorSlots) ? MaxAnchors : AnchorSlots;

  localparam int TempW    = 8;
  localparam int TgtW     = 8;
  localparam int CntW     = 4;
  localparam int IdxW     = $clog2(AnchorSlots);
  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 64;
  localparam int WordW    = 64;
  localparam int AnchorW  = 16;
  localparam int ProdW    = TempW + TgtW;
  localparam int DivSteps = ProdW;
  localparam int DivCntW  = $clog2(DivSteps);

  localparam logic [TgtW-1:0] BandReset    = 8'd3;
  localparam logic [TgtW-1:0] FallbackReset = 8'd91;

  typedef logic [TempW-1:0] temp_t;
  typedef logic [TgtW-1:0]  tgt_t;

  // Packing matches the register words: high byte target, low byte temperature.
  typedef struct packed {
    tgt_t  v;
    temp_t t;
  } anchor_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_ANCHOR_COUNT = 3'd0,
    CFG_WORD_LOW     = 3'd1,
    CFG_WORD_MID     = 3'd2,
    CFG_WORD_HIGH    = 3'd3,
    CFG_BAND         = 3'd4,
    CFG_FALLBACK     = 3'd5
  } cfg_idx_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_EVAL,
    ST_DIV_GO,
    ST_DIV_WAIT,
    ST_FINISH
  } state_e;

  function automatic anchor_t builtin_anchor(input logic [IdxW-1:0] idx);
    anchor_t res;
    case (idx)
      4'd0:    res = '{t: 8'd0,   v: 8'd91};
      4'd1:    res = '{t: 8'd40,  v: 8'd91};
      4'd2:    res = '{t: 8'd52,  v: 8'd88};
      4'd3:    res = '{t: 8'd58,  v: 8'd84};
      4'd4:    res = '{t: 8'd64,  v: 8'd75};
      4'd5:    res = '{t: 8'd70,  v: 8'd72};
      4'd6:    res = '{t: 8'd75,  v: 8'd70};
      4'd7:    res = '{t: 8'd85,  v: 8'd68};
      default: res = '{t: 8'd100, v: 8'd68};
    endcase
    return res;
  endfunction

endpackage

// ===== sv/fcth_in_if.sv =====
// ----------------------------------------------------------------------------
// fcth_in_if
// Sample channel: temperature reading and its valid flag.
// ----------------------------------------------------------------------------
interface fcth_in_if;
  import fcth_pkg::*;

  logic  valid;
  logic  ready;
  temp_t temperature;
  logic  sample_valid;

  modport source (output valid, output temperature, output sample_valid, input ready);
  modport sink   (input valid, input temperature, input sample_valid, output ready);
endinterface

// ===== sv/fcth_out_if.sv =====
// ----------------------------------------------------------------------------
// fcth_out_if
// Result channel: curve value, recommended target and the hold flag.
// ----------------------------------------------------------------------------
interface fcth_out_if;
  import fcth_pkg::*;

  logic valid;
  logic ready;
  tgt_t curve_target;
  tgt_t recommended_target;
  logic target_held;

  modport source (output valid, output curve_target, output recommended_target,
                  output target_held, input ready);
  modport sink   (input valid, input curve_target, input recommended_target,
                  input target_held, output ready);
endinterface

// ===== sv/fan_curve_target_hysteresis_core.sv =====
// ----------------------------------------------------------------------------
// fan_curve_target_hysteresis_core
// Piecewise-linear fan curve lookup followed by target hysteresis.
// ----------------------------------------------------------------------------
//  channel     dir   handshake      payload
//  in_chan_i   in    valid/ready    temperature, sample_valid
//  out_chan_o  out   valid/ready    curve_target, recommended_target, target_held
//  cfg         in    cfg_we_i       cfg_idx_i, cfg_data_i
//
// A valid sample scans the anchors one per cycle (nine for the built-in
// curve), then either clamps or interpolates, the interpolation using the
// 16-step serial divider. Reset loads the register reset values and
// forgets the last target. A stalled result waits in the output register;
// the next sample is accepted meanwhile and its result waits for that slot.
// ----------------------------------------------------------------------------
module fan_curve_target_hysteresis_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  fcth_in_if.sink                       in_chan_i,
  fcth_out_if.source                    out_chan_o,
  input  logic                          cfg_we_i,
  input  logic [fcth_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [fcth_pkg::CfgDataW-1:0] cfg_data_i
);
  import fcth_pkg::*;

  // Configuration registers
  logic [CntW-1:0]    anchor_count_q;
  logic [WordW-1:0]   word_low_q;
  logic [WordW-1:0]   word_mid_q;
  logic [AnchorW-1:0] word_high_q;
  tgt_t               band_q;
  tgt_t               fallback_q;

  // Control state
  state_e             state_q, state_d;
  logic [IdxW-1:0]    scan_idx_q, scan_idx_d;
  tgt_t               last_tgt_q, last_tgt_d;
  logic               last_known_q, last_known_d;
  logic               out_valid_q, out_valid_d;

  // Working registers
  temp_t              tc_q, tc_d;
  logic               svalid_q, svalid_d;
  logic               lo_found_q, lo_found_d;
  logic               hi_found_q, hi_found_d;
  anchor_t            lo_q, lo_d;
  anchor_t            hi_q, hi_d;
  anchor_t            max_q, max_d;
  logic [ProdW-1:0]   prod_q, prod_d;
  temp_t              dt_q, dt_d;
  logic               neg_q, neg_d;
  tgt_t               curve_q, curve_d;
  tgt_t               out_curve_q, out_curve_d;
  tgt_t               out_rec_q, out_rec_d;
  logic               out_held_q, out_held_d;

  anchor_t [AnchorSlots-1:0] cust_vec;
  anchor_t                   cur;
  logic                      use_builtin;
  logic [CntW-1:0]           n_use;
  logic [IdxW-1:0]           last_idx;
  logic                      div_start;
  logic [ProdW-1:0]          div_quo;
  div_stat_t                 div_stat;

  assign cust_vec    = {word_high_q, word_mid_q, word_low_q};
  assign use_builtin = (anchor_count_q == '0);
  assign n_use       = use_builtin ? CntW'(AnchorSlots) :
                       (anchor_count_q > CntW'(AnchorLimit)) ? CntW'(AnchorLimit) :
                       anchor_count_q;
  assign last_idx    = IdxW'(n_use - 1'b1);
  assign cur         = use_builtin ? builtin_anchor(scan_idx_q) : cust_vec[scan_idx_q];

  fcth_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (prod_q),
    .divisor_i  (dt_q),
    .quotient_o (div_quo),
    .stat_o     (div_stat)
  );

  always_comb begin
    tgt_t diff_mag;
    tgt_t dv_mag;
    logic held;
    logic out_xfer;

    state_d      = state_q;
    scan_idx_d   = scan_idx_q;
    last_tgt_d   = last_tgt_q;
    last_known_d = last_known_q;
    out_valid_d  = out_valid_q;
    tc_d         = tc_q;
    svalid_d     = svalid_q;
    lo_found_d   = lo_found_q;
    hi_found_d   = hi_found_q;
    lo_d         = lo_q;
    hi_d         = hi_q;
    max_d        = max_q;
    prod_d       = prod_q;
    dt_d         = dt_q;
    neg_d        = neg_q;
    curve_d      = curve_q;
    out_curve_d  = out_curve_q;
    out_rec_d    = out_rec_q;
    out_held_d   = out_held_q;
    div_start    = 1'b0;

    out_xfer = out_valid_q && out_chan_o.ready;
    if (out_xfer) begin
      out_valid_d = 1'b0;
    end

    diff_mag = (curve_q >= last_tgt_q) ? (curve_q - last_tgt_q) : (last_tgt_q - curve_q);
    held     = svalid_q && last_known_q && (diff_mag <= band_q);
    dv_mag   = (hi_q.v >= lo_q.v) ? (hi_q.v - lo_q.v) : (lo_q.v - hi_q.v);

    case (state_q)
      ST_IDLE: begin
        if (in_chan_i.valid) begin
          tc_d       = in_chan_i.temperature;
          svalid_d   = in_chan_i.sample_valid;
          scan_idx_d = '0;
          lo_found_d = 1'b0;
          hi_found_d = 1'b0;
          if (in_chan_i.sample_valid) begin
            state_d = ST_SCAN;
          end else begin
            curve_d = fallback_q;
            state_d = ST_FINISH;
          end
        end
      end
      ST_SCAN: begin
        // Lower anchor: hottest below the sample, later index on a tie.
        // Upper anchor: coolest at or above it, earlier index on a tie.
        if (cur.t < tc_q) begin
          if (!lo_found_q || cur.t >= lo_q.t) begin
            lo_d       = cur;
            lo_found_d = 1'b1;
          end
        end else if (!hi_found_q || cur.t < hi_q.t) begin
          hi_d       = cur;
          hi_found_d = 1'b1;
        end
        if (scan_idx_q == '0 || cur.t >= max_q.t) begin
          max_d = cur;
        end
        if (scan_idx_q == last_idx) begin
          state_d = ST_EVAL;
        end else begin
          scan_idx_d = scan_idx_q + 1'b1;
        end
      end
      ST_EVAL: begin
        if (!lo_found_q) begin
          curve_d = hi_q.v;
          state_d = ST_FINISH;
        end else if (tc_q >= max_q.t) begin
          curve_d = max_q.v;
          state_d = ST_FINISH;
        end else begin
          prod_d  = ProdW'(tc_q - lo_q.t) * ProdW'(dv_mag);
          dt_d    = hi_q.t - lo_q.t;
          neg_d   = hi_q.v < lo_q.v;
          state_d = ST_DIV_GO;
        end
      end
      ST_DIV_GO: begin
        div_start = 1'b1;
        state_d   = ST_DIV_WAIT;
      end
      ST_DIV_WAIT: begin
        if (div_stat.done) begin
          curve_d = neg_q ? (lo_q.v - div_quo[TgtW-1:0]) : (lo_q.v + div_quo[TgtW-1:0]);
          state_d = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (!out_valid_q || out_chan_o.ready) begin
          out_valid_d  = 1'b1;
          out_curve_d  = curve_q;
          out_rec_d    = held ? last_tgt_q : curve_q;
          out_held_d   = held;
          last_tgt_d   = held ? last_tgt_q : curve_q;
          last_known_d = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= ST_IDLE;
      scan_idx_q     <= '0;
      last_tgt_q     <= '0;
      last_known_q   <= 1'b0;
      out_valid_q    <= 1'b0;
      anchor_count_q <= '0;
      word_low_q     <= '0;
      word_mid_q     <= '0;
      word_high_q    <= '0;
      band_q         <= BandReset;
      fallback_q     <= FallbackReset;
    end else begin
      state_q      <= state_d;
      scan_idx_q   <= scan_idx_d;
      last_tgt_q   <= last_tgt_d;
      last_known_q <= last_known_d;
      out_valid_q  <= out_valid_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_ANCHOR_COUNT: anchor_count_q <= cfg_data_i[CntW-1:0];
          CFG_WORD_LOW:     word_low_q     <= cfg_data_i[WordW-1:0];
          CFG_WORD_MID:     word_mid_q     <= cfg_data_i[WordW-1:0];
          CFG_WORD_HIGH:    word_high_q    <= cfg_data_i[AnchorW-1:0];
          CFG_BAND:         band_q         <= cfg_data_i[TgtW-1:0];
          CFG_FALLBACK:     fallback_q     <= cfg_data_i[TgtW-1:0];
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    tc_q        <= tc_d;
    svalid_q    <= svalid_d;
    lo_found_q  <= lo_found_d;
    hi_found_q  <= hi_found_d;
    lo_q        <= lo_d;
    hi_q        <= hi_d;
    max_q       <= max_d;
    prod_q      <= prod_d;
    dt_q        <= dt_d;
    neg_q       <= neg_d;
    curve_q     <= curve_d;
    out_curve_q <= out_curve_d;
    out_rec_q   <= out_rec_d;
    out_held_q  <= out_held_d;
  end

  assign in_chan_i.ready               = (state_q == ST_IDLE);
  assign out_chan_o.valid              = out_valid_q;
  assign out_chan_o.curve_target       = out_curve_q;
  assign out_chan_o.recommended_target = out_rec_q;
  assign out_chan_o.target_held        = out_held_q;

endmodule

// ===== sv/fcth_div.sv =====
// ----------------------------------------------------------------------------
// fcth_div
// Restoring serial divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module fcth_div (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [fcth_pkg::ProdW-1:0] dividend_i,
  input  logic [fcth_pkg::TgtW-1:0]  divisor_i,
  output logic [fcth_pkg::ProdW-1:0] quotient_o,
  output fcth_pkg::div_stat_t        stat_o
);
  import fcth_pkg::*;

  logic               busy_q, busy_d;
  logic               done_q, done_d;
  logic [DivCntW-1:0] cnt_q, cnt_d;
  logic [TgtW-1:0]    rem_q, rem_d;
  logic [TgtW-1:0]    dsr_q, dsr_d;
  logic [ProdW-1:0]   quo_q, quo_d;

  logic [TgtW:0] trial;
  logic [TgtW:0] diff;
  logic          ge;

  always_comb begin
    trial  = {rem_q, quo_q[ProdW-1]};
    diff   = trial - {1'b0, dsr_q};
    ge     = trial >= {1'b0, dsr_q};
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    dsr_d  = dsr_q;
    quo_d  = quo_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      rem_d  = '0;
      dsr_d  = divisor_i;
      quo_d  = dividend_i;
    end else if (busy_q) begin
      // The partial remainder always stays below the divisor, so it fits.
      rem_d = ge ? diff[TgtW-1:0] : trial[TgtW-1:0];
      quo_d = {quo_q[ProdW-2:0], ge};
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == DivCntW'(DivSteps - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    dsr_q <= dsr_d;
    quo_q <= quo_d;
  end

  assign quotient_o  = quo_q;
  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;

endmodule

// ===== sv/fcth_checker.sv =====
// ----------------------------------------------------------------------------
// fcth_checker
// Port-level checks of the fan curve core, attached by bind.
// ----------------------------------------------------------------------------
module fcth_checker (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      in_valid_i,
  input logic                      in_ready_i,
  input logic                      out_valid_i,
  input logic                      out_ready_i,
  input logic [fcth_pkg::TgtW-1:0] curve_i,
  input logic [fcth_pkg::TgtW-1:0] rec_i,
  input logic                      held_i
);
  import fcth_pkg::*;

  logic seen_q;
  tgt_t last_rec_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_q     <= 1'b0;
      last_rec_q <= '0;
    end else if (out_valid_i && out_ready_i) begin
      seen_q     <= 1'b1;
      last_rec_q <= rec_i;
    end
  end

  // One sample at a time: the core is busy right after a transfer in.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_i) |=> !in_ready_i)
    else $error("input accepted while a sample is in work");

  // A held result repeats the previous recommendation.
  a_held_repeats: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && out_ready_i && held_i) |-> (seen_q && rec_i == last_rec_q))
    else $error("held target differs from the previous recommendation");

  // Without a hold the curve value passes straight through.
  a_pass_through: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && out_ready_i && !held_i) |-> (rec_i == curve_i))
    else $error("recommendation differs from curve value without a hold");

  a_out_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_ready_i) |=>
      (out_valid_i && $stable(curve_i) && $stable(rec_i) && $stable(held_i)))
    else $error("stalled result changed");

endmodule

bind fan_curve_target_hysteresis_core fcth_checker u_fcth_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_chan_i.valid),
  .in_ready_i  (in_chan_i.ready),
  .out_valid_i (out_chan_o.valid),
  .out_ready_i (out_chan_o.ready),
  .curve_i     (out_chan_o.curve_target),
  .rec_i       (out_chan_o.recommended_target),
  .held_i      (out_chan_o.target_held)
);
